// ===== hdl/fvn_pkg.sv =====
// Shared constants, widths and register codes for the fractal value noise block.
`timescale 1ns / 1ps
`default_nettype none

package fvn_pkg;

    localparam int COORD_W   = 32;
    localparam int VALUE_W   = 16;
    localparam int CNT_W     = 4;
    localparam int REG_IDX_W = 1;

    localparam int DEF_MAX_OCTAVES = 8;

    // Stages inside one octave lane, then one stage for the octave sum.
    localparam int OCT_STAGES = 7;
    localparam int PIPE_DEPTH = OCT_STAGES + 1;

    localparam logic [REG_IDX_W-1:0] REG_NOISE_SEED   = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'd1;

    localparam logic [COORD_W-1:0] NOISE_SEED_RESET   = 32'd0;
    localparam logic [CNT_W-1:0]   OCTAVE_COUNT_RESET = 4'd5;

    localparam logic [31:0] HASH_MUL_X = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Y = 32'd668265263;
    localparam logic [31:0] HASH_MUL_S = 32'd2246822519;
    localparam logic [31:0] HASH_MUL_F = 32'd1274126177;
    localparam logic [31:0] SEED_STEP  = 32'd131;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [17:0] SMOOTH_K  = 18'h30000;
    localparam logic [15:0] VALUE_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ===== hdl/fractal_value_noise.sv =====
// Top level of the fractal value noise block: config registers, octave lanes, sum stage.
// Pipeline: from input transfer to result, the octave lane stages in order, then
//   one stage that sums the octaves and saturates.
// Throughput: one coordinate per cycle unless out_ready stalls; all octave lanes run
//   side by side, so the rate does not depend on octave_count. A stall fills bubbles upstream.
// Reset: rst_n clears the valid bits, noise_seed to 0 and octave_count to 5.
`timescale 1ns / 1ps
`default_nettype none

module fractal_value_noise #(
    parameter int MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [fvn_pkg::REG_IDX_W-1:0]        cfg_index,
    input  wire logic [fvn_pkg::COORD_W-1:0]          cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [fvn_pkg::COORD_W-1:0]   x_pos,
    input  wire logic signed [fvn_pkg::COORD_W-1:0]   y_pos,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [fvn_pkg::VALUE_W-1:0]               noise_value
);

    localparam int DEPTH = fvn_pkg::PIPE_DEPTH;
    localparam int SUM_W = fvn_pkg::VALUE_W + $clog2(MAX_OCTAVES) + 1;

    logic [fvn_pkg::COORD_W-1:0] noise_seed_reg;
    logic [fvn_pkg::CNT_W-1:0]   octave_count_reg;

    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [DEPTH:0]   stage_rdy;

    logic [fvn_pkg::VALUE_W-1:0] oct_value [MAX_OCTAVES];
    logic [SUM_W-1:0]            acc;
    logic [fvn_pkg::VALUE_W-1:0] noise_value_next, noise_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_seed_reg   <= fvn_pkg::NOISE_SEED_RESET;
            octave_count_reg <= fvn_pkg::OCTAVE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fvn_pkg::REG_NOISE_SEED:   noise_seed_reg   <= cfg_data;
                fvn_pkg::REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[fvn_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage advances when it is empty or the stage after it advances
    always_comb
    begin
        stage_rdy[DEPTH] = out_ready;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            stage_rdy[k] = !valid_reg[k] || stage_rdy[k + 1];
        end
        valid_next[0] = stage_rdy[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < DEPTH; k++)
        begin
            valid_next[k] = stage_rdy[k] ? valid_reg[k - 1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_oct
        fvn_octave #(
            .OCT (i)
        ) u_oct (
            .clk        (clk),
            .adv        (stage_rdy[fvn_pkg::OCT_STAGES-1:0]),
            .x_pos      (x_pos),
            .y_pos      (y_pos),
            .noise_seed (noise_seed_reg),
            .oct_value  (oct_value[i])
        );
    end

    // sum the enabled octaves; indexes past octave_count drop out
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < MAX_OCTAVES; i++)
        begin
            if (octave_count_reg > fvn_pkg::CNT_W'(i))
            begin
                acc = acc + SUM_W'(oct_value[i]);
            end
        end
        if (acc > SUM_W'(fvn_pkg::VALUE_MAX))
        begin
            noise_value_next = fvn_pkg::VALUE_MAX;
        end
        else
        begin
            noise_value_next = acc[fvn_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[DEPTH-1])
        begin
            noise_value_reg <= noise_value_next;
        end
    end

    assign in_ready    = stage_rdy[0];
    assign out_valid   = valid_reg[DEPTH-1];
    assign noise_value = noise_value_reg;

`ifndef SYNTHESIS
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output side is ready");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> valid_reg[0])
        else $error("input stalled with an empty first stage");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("transfer did not reach the first stage");

    a_reach_out: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[DEPTH-2] && stage_rdy[DEPTH-1]) |=> out_valid)
        else $error("item lost before the output register");
`endif

endmodule

`default_nettype wire

// ===== hdl/fvn_octave.sv =====
// One octave lane: lattice hash, smoothstep and bilinear blend, seven register stages.
`timescale 1ns / 1ps
`default_nettype none

module fvn_octave #(
    parameter int OCT = 0
) (
    input  wire logic                               clk,
    input  wire logic [fvn_pkg::OCT_STAGES-1:0]     adv,
    input  wire logic signed [fvn_pkg::COORD_W-1:0] x_pos,
    input  wire logic signed [fvn_pkg::COORD_W-1:0] y_pos,
    input  wire logic [fvn_pkg::COORD_W-1:0]        noise_seed,
    output logic [fvn_pkg::VALUE_W-1:0]             oct_value
);

    function automatic logic [31:0] q16_mul(input logic [15:0] a, input logic [16:0] w);
        logic [32:0] p;
        p = {17'd0, a} * {16'd0, w};
        return p[31:0];
    endfunction

    // stage 1: lattice cells and fractions
    logic [63:0] x_wide, y_wide;
    logic [31:0] x0_next, x1_next, y0_next, y1_next, seed_next;
    logic [15:0] fx_next, fy_next;
    logic [31:0] x0_reg, x1_reg, y0_reg, y1_reg, seed_reg;
    logic [15:0] fx_reg, fy_reg;

    // stage 2: hash products, smoothstep first product
    logic [31:0] px0_next, px1_next, py0_next, py1_next, ps_next;
    logic [31:0] ffx_next, ffy_next;
    logic [17:0] tx_next, ty_next;
    logic [31:0] px0_reg, px1_reg, py0_reg, py1_reg, ps_reg;
    logic [31:0] ffx_reg, ffy_reg;
    logic [17:0] tx_reg, ty_reg;

    // stage 3: hash sum and first xorshift, smoothstep result
    logic [31:0] hs [4];
    logic [31:0] g_next [4];
    logic [31:0] g_reg [4];
    logic [49:0] sxp, syp;
    logic [15:0] sx3_next, sy3_next, sx3_reg, sy3_reg;

    // stage 4: final hash multiply
    logic [31:0] m_next [4];
    logic [31:0] m_reg [4];
    logic [15:0] sx4_reg, sy4_reg;

    // stage 5: blend along x
    logic [16:0] wx;
    logic [31:0] pa_next [4];
    logic [31:0] pa_reg [4];
    logic [15:0] sy5_reg;

    // stage 6: blend along y
    logic [31:0] row0, row1;
    logic [16:0] wy;
    logic [31:0] qa_next, qb_next, qa_reg, qb_reg;

    // stage 7: octave weight
    logic [31:0] oct_sum;
    logic [15:0] oct_value_next, oct_value_reg;

    always_comb
    begin
        x_wide    = {{32{x_pos[31]}}, x_pos} << OCT;
        y_wide    = {{32{y_pos[31]}}, y_pos} << OCT;
        x0_next   = x_wide[47:16];
        x1_next   = x_wide[47:16] + 32'd1;
        y0_next   = y_wide[47:16];
        y1_next   = y_wide[47:16] + 32'd1;
        fx_next   = x_wide[15:0];
        fy_next   = y_wide[15:0];
        seed_next = noise_seed + 32'(OCT) * fvn_pkg::SEED_STEP;
    end

    always_comb
    begin
        px0_next = x0_reg * fvn_pkg::HASH_MUL_X;
        px1_next = x1_reg * fvn_pkg::HASH_MUL_X;
        py0_next = y0_reg * fvn_pkg::HASH_MUL_Y;
        py1_next = y1_reg * fvn_pkg::HASH_MUL_Y;
        ps_next  = seed_reg * fvn_pkg::HASH_MUL_S;
        ffx_next = {16'd0, fx_reg} * {16'd0, fx_reg};
        ffy_next = {16'd0, fy_reg} * {16'd0, fy_reg};
        tx_next  = fvn_pkg::SMOOTH_K - {1'b0, fx_reg, 1'b0};
        ty_next  = fvn_pkg::SMOOTH_K - {1'b0, fy_reg, 1'b0};
    end

    always_comb
    begin
        // corner order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
        hs[0] = px0_reg + py0_reg + ps_reg;
        hs[1] = px1_reg + py0_reg + ps_reg;
        hs[2] = px0_reg + py1_reg + ps_reg;
        hs[3] = px1_reg + py1_reg + ps_reg;
        for (int c = 0; c < 4; c++)
        begin
            g_next[c] = hs[c] ^ (hs[c] >> 13);
        end
        sxp      = {18'd0, ffx_reg} * {32'd0, tx_reg};
        syp      = {18'd0, ffy_reg} * {32'd0, ty_reg};
        sx3_next = sxp[47:32];
        sy3_next = syp[47:32];
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            m_next[c] = g_reg[c] * fvn_pkg::HASH_MUL_F;
        end
    end

    always_comb
    begin
        // top half of h ^ (h >> 16) is just the top half of h
        wx         = fvn_pkg::ONE_Q16 - {1'b0, sx4_reg};
        pa_next[0] = q16_mul(m_reg[0][31:16], wx);
        pa_next[1] = q16_mul(m_reg[1][31:16], {1'b0, sx4_reg});
        pa_next[2] = q16_mul(m_reg[2][31:16], wx);
        pa_next[3] = q16_mul(m_reg[3][31:16], {1'b0, sx4_reg});
    end

    always_comb
    begin
        row0    = pa_reg[0] + pa_reg[1];
        row1    = pa_reg[2] + pa_reg[3];
        wy      = fvn_pkg::ONE_Q16 - {1'b0, sy5_reg};
        qa_next = q16_mul(row0[31:16], wy);
        qb_next = q16_mul(row1[31:16], {1'b0, sy5_reg});
    end

    always_comb
    begin
        oct_sum        = qa_reg + qb_reg;
        oct_value_next = oct_sum[31:16] >> (OCT + 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            x0_reg   <= x0_next;
            x1_reg   <= x1_next;
            y0_reg   <= y0_next;
            y1_reg   <= y1_next;
            fx_reg   <= fx_next;
            fy_reg   <= fy_next;
            seed_reg <= seed_next;
        end
        if (adv[1])
        begin
            px0_reg <= px0_next;
            px1_reg <= px1_next;
            py0_reg <= py0_next;
            py1_reg <= py1_next;
            ps_reg  <= ps_next;
            ffx_reg <= ffx_next;
            ffy_reg <= ffy_next;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
        end
        if (adv[2])
        begin
            g_reg   <= g_next;
            sx3_reg <= sx3_next;
            sy3_reg <= sy3_next;
        end
        if (adv[3])
        begin
            m_reg   <= m_next;
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
        end
        if (adv[4])
        begin
            pa_reg  <= pa_next;
            sy5_reg <= sy4_reg;
        end
        if (adv[5])
        begin
            qa_reg <= qa_next;
            qb_reg <= qb_next;
        end
        if (adv[6])
        begin
            oct_value_reg <= oct_value_next;
        end
    end

    assign oct_value = oct_value_reg;

endmodule

`default_nettype wire

// ===== tb/noise_checker.sv =====
// Checker for the fractal value noise block: tracks the config, predicts each result and compares.
`timescale 1ns / 1ps

module noise_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fvn_pkg::REG_IDX_W-1:0]       cfg_index,
    input  logic [fvn_pkg::COORD_W-1:0]         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [fvn_pkg::COORD_W-1:0]  x_pos,
    input  logic signed [fvn_pkg::COORD_W-1:0]  y_pos,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [fvn_pkg::VALUE_W-1:0]         noise_value,
    output int                                  fail_count,
    output int                                  pending
);

    logic [fvn_pkg::COORD_W-1:0] seed_reg;
    logic [fvn_pkg::CNT_W-1:0]   octaves_reg;
    logic [fvn_pkg::VALUE_W-1:0] noise_q[$];

    // Multiply-xor lattice hash; the corner value is the top half of the hash.
    function automatic logic [15:0] lattice_value(input logic [31:0] cx, input logic [31:0] cy,
                                                  input logic [31:0] seed);
        logic [31:0] h;
        h = cx * fvn_pkg::HASH_MUL_X + cy * fvn_pkg::HASH_MUL_Y + seed * fvn_pkg::HASH_MUL_S;
        h = (h ^ (h >> 13)) * fvn_pkg::HASH_MUL_F;
        h = h ^ (h >> 16);
        return h[31:16];
    endfunction

    function automatic logic [15:0] smooth_frac(input logic [15:0] f);
        logic [63:0] sq;
        logic [63:0] w;
        sq = 64'(f) * 64'(f);
        w  = 64'(fvn_pkg::SMOOTH_K) - 64'(f) * 64'd2;
        return 16'((sq * w) >> 32);
    endfunction

    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] s);
        logic [63:0] acc;
        acc = 64'(a) * (64'(fvn_pkg::ONE_Q16) - 64'(s)) + 64'(b) * 64'(s);
        return 16'(acc >> 16);
    endfunction

    function automatic logic [15:0] octave_value(input logic [63:0] xs, input logic [63:0] ys,
                                                 input logic [31:0] seed);
        logic [31:0] x0;
        logic [31:0] y0;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] top_row;
        logic [15:0] bot_row;
        x0 = xs[47:16];
        y0 = ys[47:16];
        sx = smooth_frac(xs[15:0]);
        sy = smooth_frac(ys[15:0]);
        top_row = blend(lattice_value(x0, y0, seed), lattice_value(x0 + 32'd1, y0, seed), sx);
        bot_row = blend(lattice_value(x0, y0 + 32'd1, seed),
                        lattice_value(x0 + 32'd1, y0 + 32'd1, seed), sx);
        return blend(top_row, bot_row, sy);
    endfunction

    function automatic logic [15:0] fbm_noise(input logic signed [31:0] x,
                                              input logic signed [31:0] y,
                                              input logic [31:0] seed,
                                              input logic [3:0] octaves);
        logic [63:0] xe;
        logic [63:0] ye;
        logic [31:0] acc;
        logic [31:0] v;
        int n;
        int i;
        xe = {{32{x[31]}}, x};
        ye = {{32{y[31]}}, y};
        n = (int'(octaves) > fvn_pkg::DEF_MAX_OCTAVES) ? fvn_pkg::DEF_MAX_OCTAVES
                                                        : int'(octaves);
        acc = 32'd0;
        for (i = 0; i < n; i++) begin
            v = 32'(octave_value(xe << i, ye << i, seed + 32'(i) * fvn_pkg::SEED_STEP));
            acc = acc + (v >> (i + 1));
        end
        return (acc > 32'(fvn_pkg::VALUE_MAX)) ? fvn_pkg::VALUE_MAX : acc[15:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        fail_count++;
        $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seed_reg    = fvn_pkg::NOISE_SEED_RESET;
            octaves_reg = fvn_pkg::OCTAVE_COUNT_RESET;
            noise_q.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (noise_q.size() == 0)
                    report_mismatch("noise_value with no transfer outstanding", 16'h0,
                                    noise_value);
                else if (noise_value !== noise_q[0])
                    report_mismatch("noise_value", noise_q.pop_front(), noise_value);
                else
                    void'(noise_q.pop_front());
            end
            if (in_valid && in_ready)
                noise_q.push_back(fbm_noise(x_pos, y_pos, seed_reg, octaves_reg));
            // New register values apply to transfers after this edge.
            if (cfg_we) begin
                if (cfg_index == fvn_pkg::REG_NOISE_SEED)
                    seed_reg = cfg_data;
                else if (cfg_index == fvn_pkg::REG_OCTAVE_COUNT)
                    octaves_reg = cfg_data[fvn_pkg::CNT_W-1:0];
            end
        end
        pending <= noise_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the fractal value noise block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int N_PHASES    = 8;
    localparam int N_DIRECTED  = 12;
    localparam int HOLD_OFF    = 300;
    localparam int STALL_LIMIT = 3000;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [fvn_pkg::REG_IDX_W-1:0] cfg_index = fvn_pkg::REG_NOISE_SEED;
    logic [fvn_pkg::COORD_W-1:0]   cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [fvn_pkg::COORD_W-1:0]   x_pos = '0;
    logic [fvn_pkg::COORD_W-1:0]   y_pos = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [fvn_pkg::VALUE_W-1:0]   noise_value;

    int fail_count;
    int pending;
    int stall_cycles = 0;
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;

    logic [31:0] dir_x[N_DIRECTED] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF,
                                       32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000,
                                       32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                                       32'h7FFF_0000, 32'h1234_5678, 32'hFFFF_8000};
    logic [31:0] dir_y[N_DIRECTED] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF,
                                       32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000,
                                       32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_0000,
                                       32'h8000_FFFF, 32'h9ABC_DEF0, 32'h0000_7FFF};

    always #5 clk = ~clk;

    fractal_value_noise DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .noise_value (noise_value)
    );

    noise_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_pos       (x_pos),
        .y_pos       (y_pos),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .noise_value (noise_value),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom();
            2: v = $urandom_range(0, 32'h7FFFF) - 32'h40000;
            3: v = {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), 16'($urandom())};
            4: v = {16'($urandom()), ($urandom_range(0, 1) ? 16'h0000 : 16'hFFFF)};
            default: v = {($urandom_range(0, 1) ? 16'hFFFF : 16'h0000), 16'($urandom())};
        endcase
        return v;
    endfunction

    task automatic push_coord(input logic [31:0] x, input logic [31:0] y, input int gap);
        in_valid <= 1'b1;
        x_pos    <= x;
        y_pos    <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every outstanding result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [fvn_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int k;
        int burst_left;
        int gap;
        burst_left = 0;
        for (k = 0; k < count; k++) begin
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else begin
                if ($urandom_range(0, 39) == 0)
                    burst_left = $urandom_range(20, 50);
                gap = pick_gap();
            end
            push_coord(rand_coord(), rand_coord(), gap);
        end
    endtask

    // Receiver: random back-pressure, long ready stretches, and one long hold-off on request.
    initial begin
        int hold;
        forever begin
            if (hold_off_req && !hold_off_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
                hold_off_done = 1'b1;
            end else begin
                hold = pick_gap();
                if (hold > 0) begin
                    out_ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(30, 100)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] seed_tab[N_PHASES];
        logic [31:0] octave_tab[N_PHASES];
        int          random_tab[N_PHASES];
        int          p;
        int          d;

        seed_tab   = '{fvn_pkg::NOISE_SEED_RESET, 32'hFFFF_FFFF, $urandom(), 32'h8000_0000,
                       $urandom(), 32'h0000_0000, $urandom(), 32'h1234_5678};
        // Upper data bits beyond the 4-bit count are junk on purpose.
        octave_tab = '{32'(fvn_pkg::OCTAVE_COUNT_RESET), 32'd8, 32'd1, 32'd0,
                       32'd15, 32'hFFFF_FFF3, 32'($urandom_range(1, 8)), 32'h0000_0009};
        random_tab = '{150, 150, 150, 60, 150, 150, 150, 150};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                drain();
                write_reg(fvn_pkg::REG_NOISE_SEED, seed_tab[p]);
                write_reg(fvn_pkg::REG_OCTAVE_COUNT, octave_tab[p]);
                cfg_we <= 1'b0;
            end
            if (p == 0) begin
                for (d = 0; d < N_DIRECTED; d++)
                    push_coord(dir_x[d], dir_y[d], pick_gap());
            end else if (p == 3 || p == 4) begin
                // Zero octaves and an over-range count on the coordinate extremes.
                for (d = 4; d < 8; d++)
                    push_coord(dir_x[d], dir_y[d], pick_gap());
            end
            if (p == 1) begin
                // Keep offering while the receiver holds off, so the pipeline backs up.
                hold_off_req = 1'b1;
                while (!hold_off_done)
                    push_coord(rand_coord(), rand_coord(), 0);
            end
            if (p == 6) begin
                run_random(random_tab[p] / 2);
                drain();
                run_random(random_tab[p] - random_tab[p] / 2);
            end else begin
                run_random(random_tab[p]);
            end
        end

        drain();
        repeat (2 * fvn_pkg::PIPE_DEPTH) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
